FILE: sv/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion converter.
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int IN_W          = 16;   // matrix entry and quaternion component width
    localparam int D_W           = 17;   // off-diagonal sum or difference
    localparam int BEST_W        = 17;   // largest candidate, never negative
    localparam int Q_W           = 33;   // quotient bits: d^2 * 2^F / t <= 2^32
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] CASE_W = 2'd0;
    localparam logic [1:0] CASE_X = 2'd1;
    localparam logic [1:0] CASE_Y = 2'd2;
    localparam logic [1:0] CASE_Z = 2'd3;

    // One classified matrix; lanes hold the three smaller components in w, x, y, z order.
    typedef struct packed {
        logic [BEST_W-1:0]      best;
        logic signed [D_W-1:0]  d0;
        logic signed [D_W-1:0]  d1;
        logic signed [D_W-1:0]  d2;
        logic [1:0]             sel;
    } item_t;

endpackage

FILE: sv/rmq_front.sv
// Front end: takes a matrix, picks the largest candidate, forms the off-diagonal terms.
module rmq_front
    import rmq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic signed [IN_W-1:0] m11,
    input  logic signed [IN_W-1:0] m12,
    input  logic signed [IN_W-1:0] m13,
    input  logic signed [IN_W-1:0] m21,
    input  logic signed [IN_W-1:0] m22,
    input  logic signed [IN_W-1:0] m23,
    input  logic signed [IN_W-1:0] m31,
    input  logic signed [IN_W-1:0] m32,
    input  logic signed [IN_W-1:0] m33,
    input  logic                  q_full,
    output logic                  q_push,
    output item_t                 q_item
);

    logic          vld_reg, vld_next;
    item_t         item_reg, item_next;
    logic signed [IN_W+1:0] c0, c1, c2, c3, best;
    logic [1:0]    sel;
    logic signed [D_W-1:0] a23m32, a31m13, a12m21, a12p21, a31p13, a23p32;
    logic          accept;

    always_comb
    begin
        c0 = (IN_W+2)'(m11) + (IN_W+2)'(m22) + (IN_W+2)'(m33);
        c1 = (IN_W+2)'(m11) - (IN_W+2)'(m22) - (IN_W+2)'(m33);
        c2 = (IN_W+2)'(m22) - (IN_W+2)'(m11) - (IN_W+2)'(m33);
        c3 = (IN_W+2)'(m33) - (IN_W+2)'(m11) - (IN_W+2)'(m22);
        best = c0;
        sel  = CASE_W;
        // strict compares: earlier candidate keeps a tie
        if (c1 > best)
        begin
            best = c1;
            sel  = CASE_X;
        end
        if (c2 > best)
        begin
            best = c2;
            sel  = CASE_Y;
        end
        if (c3 > best)
        begin
            best = c3;
            sel  = CASE_Z;
        end

        a23m32 = D_W'(m23) - D_W'(m32);
        a31m13 = D_W'(m31) - D_W'(m13);
        a12m21 = D_W'(m12) - D_W'(m21);
        a12p21 = D_W'(m12) + D_W'(m21);
        a31p13 = D_W'(m31) + D_W'(m13);
        a23p32 = D_W'(m23) + D_W'(m32);

        item_next.best = best[BEST_W-1:0];
        item_next.sel  = sel;
        case (sel)
            CASE_W:
            begin
                item_next.d0 = a23m32;
                item_next.d1 = a31m13;
                item_next.d2 = a12m21;
            end
            CASE_X:
            begin
                item_next.d0 = a23m32;
                item_next.d1 = a12p21;
                item_next.d2 = a31p13;
            end
            CASE_Y:
            begin
                item_next.d0 = a31m13;
                item_next.d1 = a12p21;
                item_next.d2 = a23p32;
            end
            default:
            begin
                item_next.d0 = a12m21;
                item_next.d1 = a31p13;
                item_next.d2 = a23p32;
            end
        endcase
    end

    assign q_push   = vld_reg && !q_full;
    assign in_ready = !vld_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign q_item   = item_reg;

    always_comb
    begin
        vld_next = vld_reg;
        if (accept)
            vld_next = 1'b1;
        else if (q_push)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_next;
    end

endmodule

FILE: sv/rmq_queue.sv
// Short request queue between the front end and the arithmetic pipeline.
module rmq_queue
    import rmq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  empty,
    output item_t head_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     count_reg, count_next;

    assign full      = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_item = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");
`endif

endmodule

FILE: sv/rmq_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module rmq_div #(
    parameter int Q_W  = 33,
    parameter int SH_W = 14,
    parameter int DV_W = 18
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [Q_W+SH_W-1:0]  num,
    input  logic [DV_W-1:0]      den,
    output logic [Q_W-1:0]       quo
);

    // the quotient fits Q_W bits, so the top SH_W bits of num start below den
    logic [DV_W-1:0] rem_reg  [Q_W];
    logic [Q_W-1:0]  bits_reg [Q_W];
    logic [DV_W-1:0] den_reg  [Q_W-1];

    for (genvar s = 0; s < Q_W; s++)
    begin : g_stage
        logic [DV_W-1:0] rem_p, den_p;
        logic [Q_W-1:0]  bits_p;
        logic [DV_W:0]   trial, diff;
        logic            ge;

        if (s == 0)
        begin : g_first
            assign rem_p  = DV_W'(num[Q_W+SH_W-1:Q_W]);
            assign bits_p = num[Q_W-1:0];
            assign den_p  = den;
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[s-1];
            assign bits_p = bits_reg[s-1];
            assign den_p  = den_reg[s-1];
        end

        always_comb
        begin
            trial = {rem_p, bits_p[Q_W-1]};
            diff  = trial - {1'b0, den_p};
            ge    = (trial >= {1'b0, den_p});
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? diff[DV_W-1:0] : trial[DV_W-1:0];
                bits_reg[s] <= {bits_p[Q_W-2:0], ge};
            end
        end

        if (s < Q_W-1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (en)
                    den_reg[s] <= den_p;
            end
        end
    end

    assign quo = bits_reg[Q_W-1];

endmodule

FILE: sv/rmq_sqrt.sv
// Pipelined integer square root, one root bit per stage, remainder kept for rounding.
module rmq_sqrt #(
    parameter int RAD_W = 33
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [RAD_W-1:0]         rad,
    output logic [(RAD_W+1)/2-1:0]   root,
    output logic [(RAD_W+1)/2+1:0]   rem
);

    localparam int N   = (RAD_W + 1) / 2;
    localparam int R_W = N + 2;

    logic [R_W-1:0] rem_reg  [N];
    logic [N-1:0]   root_reg [N];
    logic [2*N-1:0] xs_reg   [N-1];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        logic [R_W-1:0] rem_p, rem_sh, trial, diff;
        logic [N-1:0]   root_p;
        logic [2*N-1:0] xs_p;
        logic           ge;

        if (s == 0)
        begin : g_first
            assign rem_p  = '0;
            assign root_p = '0;
            assign xs_p   = (2*N)'(rad);
        end
        else
        begin : g_next
            assign rem_p  = rem_reg[s-1];
            assign root_p = root_reg[s-1];
            assign xs_p   = xs_reg[s-1];
        end

        always_comb
        begin
            rem_sh = {rem_p[R_W-3:0], xs_p[2*N-1:2*N-2]};
            trial  = {root_p, 2'b01};
            diff   = rem_sh - trial;
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? diff : rem_sh;
                root_reg[s] <= {root_p[N-2:0], ge};
            end
        end

        if (s < N-1)
        begin : g_xs
            always_ff @(posedge clk)
            begin
                if (en)
                    xs_reg[s] <= {xs_p[2*N-3:0], 2'b00};
            end
        end
    end

    assign root = root_reg[N-1];
    assign rem  = rem_reg[N-1];

endmodule

FILE: sv/rmq_back.sv
// Back end: square root of the pivot, three divide and root lanes, rounding and output register.
module rmq_back
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_empty,
    input  item_t                  q_item,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [IN_W-1:0] qx,
    output logic signed [IN_W-1:0] qy,
    output logic signed [IN_W-1:0] qz,
    output logic signed [IN_W-1:0] qw,
    output logic [1:0]             largest_case
);

    localparam int T_W    = ((FRAC_BITS > BEST_W) ? FRAC_BITS : BEST_W) + 1;
    localparam int Y_W    = Q_W + FRAC_BITS;
    localparam int X_W    = T_W + FRAC_BITS - 2;
    localparam int DIV_L  = Q_W;
    localparam int SQ_W   = (Q_W + 1) / 2;
    localparam int BIG_N  = (X_W + 1) / 2;
    localparam int SD     = DIV_L + SQ_W;
    localparam int BD     = SD - BIG_N;
    localparam int P      = SD + 2;
    localparam int M_W    = D_W;

    localparam logic [SQ_W-1:0]  POS_LIM = SQ_W'(32767);
    localparam logic [SQ_W-1:0]  NEG_LIM = SQ_W'(32768);
    localparam logic [BIG_N:0]   BIG_LIM = (BIG_N+1)'(32767);

    logic              vld_reg [P];
    logic              en;

    logic [T_W-1:0]    t_a_reg;
    logic [Y_W-1:0]    y_a_reg [3];
    logic [2:0]        neg_a_reg;
    logic [1:0]        sel_a_reg;

    logic [1:0]        sel_dly [SD];
    logic [2:0]        neg_dly [SD];
    logic [IN_W-1:0]   big_dly [BD];

    logic signed [D_W-1:0] d_in [3];
    logic [M_W-1:0]        mag [3];
    logic [2*M_W-1:0]      sq  [3];

    logic [BIG_N-1:0]  big_root;
    logic [BIG_N+1:0]  big_rem;
    logic [BIG_N:0]    big_rnd;
    logic [IN_W-1:0]   big_val;

    logic [IN_W-1:0]   lane_val [3];
    logic [IN_W-1:0]   qx_next, qy_next, qz_next, qw_next;

    assign en    = !vld_reg[P-1] || out_ready;
    assign q_pop = en && !q_empty;

    assign d_in[0] = q_item.d0;
    assign d_in[1] = q_item.d1;
    assign d_in[2] = q_item.d2;

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic [Q_W-1:0]  quo;
        logic [SQ_W-1:0] root;
        logic [SQ_W+1:0] rem_unused;
        logic [SQ_W:0]   inc;
        logic [SQ_W-1:0] n;
        logic            neg;

        always_comb
        begin
            mag[l] = d_in[l][D_W-1] ? M_W'(-d_in[l]) : M_W'(d_in[l]);
            sq[l]  = mag[l] * mag[l];
        end

        always_ff @(posedge clk)
        begin
            if (en)
                y_a_reg[l] <= {sq[l][Q_W-1:0], {FRAC_BITS{1'b0}}};
        end

        rmq_div #(.Q_W(Q_W), .SH_W(FRAC_BITS), .DV_W(T_W)) u_div (
            .clk (clk),
            .en  (en),
            .num (y_a_reg[l]),
            .den (t_a_reg),
            .quo (quo)
        );

        rmq_sqrt #(.RAD_W(Q_W)) u_sqrt (
            .clk  (clk),
            .en   (en),
            .rad  (quo),
            .root (root),
            .rem  (rem_unused)
        );

        // (isqrt(q) + 1) / 2, then saturate by sign
        always_comb
        begin
            inc = {1'b0, root} + 1'b1;
            n   = inc[SQ_W:1];
            neg = neg_dly[SD-1][l];
            if (neg)
                lane_val[l] = (n > NEG_LIM) ? 16'h8000 : IN_W'(SQ_W'(0) - n);
            else
                lane_val[l] = (n > POS_LIM) ? 16'h7fff : n[IN_W-1:0];
        end
    end

    rmq_sqrt #(.RAD_W(X_W)) u_big (
        .clk  (clk),
        .en   (en),
        .rad  ({t_a_reg, {(FRAC_BITS-2){1'b0}}}),
        .root (big_root),
        .rem  (big_rem)
    );

    always_comb
    begin
        // round to nearest: bump when the remainder passes the root
        big_rnd = {1'b0, big_root} + ((big_rem > (BIG_N+2)'(big_root)) ? 1'b1 : 1'b0);
        big_val = (big_rnd > BIG_LIM) ? 16'h7fff : IN_W'(big_rnd);
    end

    always_comb
    begin
        qw_next = lane_val[0];
        qx_next = lane_val[1];
        qy_next = lane_val[2];
        qz_next = big_dly[BD-1];
        case (sel_dly[SD-1])
            CASE_W:
            begin
                qw_next = big_dly[BD-1];
                qx_next = lane_val[0];
                qy_next = lane_val[1];
                qz_next = lane_val[2];
            end
            CASE_X:
            begin
                qx_next = big_dly[BD-1];
                qy_next = lane_val[1];
                qz_next = lane_val[2];
            end
            CASE_Y:
            begin
                qy_next = big_dly[BD-1];
                qz_next = lane_val[2];
            end
            default:
            begin
                qz_next = big_dly[BD-1];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_a_reg   <= T_W'(q_item.best) + (T_W'(1) << FRAC_BITS);
            neg_a_reg <= {d_in[2][D_W-1], d_in[1][D_W-1], d_in[0][D_W-1]};
            sel_a_reg <= q_item.sel;
            sel_dly[0] <= sel_a_reg;
            neg_dly[0] <= neg_a_reg;
            for (int k = 1; k < SD; k++)
            begin
                sel_dly[k] <= sel_dly[k-1];
                neg_dly[k] <= neg_dly[k-1];
            end
            big_dly[0] <= big_val;
            for (int k = 1; k < BD; k++)
                big_dly[k] <= big_dly[k-1];
            qx <= qx_next;
            qy <= qy_next;
            qz <= qz_next;
            qw <= qw_next;
            largest_case <= sel_dly[SD-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < P; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= !q_empty;
            for (int k = 1; k < P; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign out_valid = vld_reg[P-1];

`ifndef NO_ASSERTIONS
    a_big_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((largest_case == CASE_W && !qw[IN_W-1]) ||
                       (largest_case == CASE_X && !qx[IN_W-1]) ||
                       (largest_case == CASE_Y && !qy[IN_W-1]) ||
                       (largest_case == CASE_Z && !qz[IN_W-1])))
        else $error("largest component came out negative");
    a_pop_flows: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> vld_reg[0])
        else $error("popped request lost at pipeline entry");
`endif

endmodule

FILE: sv/rotation_matrix_to_quaternion_top.sv
// With an empty queue, an accepted request passes the front register, the queue entry,
// 1 squaring stage, 33 divider stages, 17 root stages and the output register on its way
// to out_valid (at FRAC_BITS = 14).
// Throughput: one matrix per cycle while the output is not stalled; the divider and root stages are fully pipelined.
// A stalled output freezes the back pipeline; the queue keeps the front accepting until it fills.
// Reset (rst_n, asynchronous, active low) clears valid bits, queue pointers and counts only.
module rotation_matrix_to_quaternion_top
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [IN_W-1:0] m11,
    input  logic signed [IN_W-1:0] m12,
    input  logic signed [IN_W-1:0] m13,
    input  logic signed [IN_W-1:0] m21,
    input  logic signed [IN_W-1:0] m22,
    input  logic signed [IN_W-1:0] m23,
    input  logic signed [IN_W-1:0] m31,
    input  logic signed [IN_W-1:0] m32,
    input  logic signed [IN_W-1:0] m33,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [IN_W-1:0] qx,
    output logic signed [IN_W-1:0] qy,
    output logic signed [IN_W-1:0] qz,
    output logic signed [IN_W-1:0] qw,
    output logic [1:0]             largest_case
);

    logic  q_full, q_push, q_pop, q_empty;
    item_t push_item, head_item;

    rmq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .m11      (m11),
        .m12      (m12),
        .m13      (m13),
        .m21      (m21),
        .m22      (m22),
        .m23      (m23),
        .m31      (m31),
        .m32      (m32),
        .m33      (m33),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rmq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head_item (head_item)
    );

    rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_item       (head_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .qx           (qx),
        .qy           (qy),
        .qz           (qz),
        .qw           (qw),
        .largest_case (largest_case)
    );

endmodule
